/* sv/mlst_pkg.sv */
package mlst_pkg;

  localparam int unsigned LimW   = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned PcW    = 13;
  localparam logic [PcW-1:0] PcMax = '1;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRY,
    S_CLR,
    S_RDI,
    S_EVAL,
    S_PRD,
    S_MUL,
    S_WR,
    S_SFRD,
    S_SFWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [1:0] mu;
    logic [CountW-1:0] sf;
    logic [PcW-1:0]    pc;
    status_e           status;
  } res_t;

endpackage

/* sv/mobius_linear_sieve_table.sv */
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | cmd_i, index_i
// out     | output    | out_valid_o / out_ready_i | mobius_value_o, squarefree_count_o,
//         |           |                           | prime_count_o, status_o
// cfg     | input     | cfg_we_i (no wait)        | cfg_wdata_i
//
// a query is one entry-memory and prefix-memory read, then the result register
// a build for limit L runs the clear sweep over entries 0..L, the single-port walk of the
// sieve, whose steps are the marks written plus one step for each number whose walk ends
// past L, and the prefix pass
// reset clears the sequencer, built limit and prime count; the table memories are not cleared
// one item is in work at a time; the next beat is taken while a result waits in the
// output register
module mobius_linear_sieve_table #(
  parameter int unsigned MAX_N       = 65535,
  parameter int unsigned PRIME_DEPTH = 8192
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [15:0]                       index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [1:0]                 mobius_value_o,
  output logic [15:0]                       squarefree_count_o,
  output logic [12:0]                       prime_count_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [15:0]                       cfg_wdata_i
);

  localparam int unsigned LW = mlst_pkg::LimW;

  logic [LW-1:0]   sieve_limit_q, sieve_limit_d;
  logic [LW-1:0]   lim_eff;
  logic            start, idle, res_valid, res_ready;
  mlst_pkg::res_t  res, out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // config register; the user must write it only while idle, the block does not enforce it
  assign sieve_limit_d = cfg_we_i ? cfg_wdata_i : sieve_limit_q;

  // zero raised to one, saturate at MAX_N
  always_comb begin
    if (sieve_limit_q == '0) begin
      lim_eff = LW'(1);
    end else if (32'(sieve_limit_q) > 32'(MAX_N)) begin
      lim_eff = LW'(MAX_N);
    end else begin
      lim_eff = sieve_limit_q;
    end
  end

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;

  mlst_engine #(
    .MAX_N      (MAX_N),
    .PRIME_DEPTH(PRIME_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (mlst_pkg::cmd_e'(cmd_i)),
    .index_i    (index_i),
    .lim_i      (lim_eff),
    .idle_o     (idle),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register parts the engine from the consumer
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);
  assign out_d       = (res_valid && res_ready) ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_limit_q <= 16'hffff;
      out_valid_q   <= 1'b0;
    end else begin
      sieve_limit_q <= sieve_limit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign mobius_value_o     = out_q.mu;
  assign squarefree_count_o = out_q.sf;
  assign prime_count_o      = out_q.pc;
  assign status_o           = out_q.status;

endmodule

/* sv/mlst_pf_mem.sv */
module mlst_pf_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [mlst_pkg::CountW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [mlst_pkg::CountW-1:0]   rdata_o
);

  logic [mlst_pkg::CountW-1:0] mem [DEPTH];
  logic [mlst_pkg::CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mlst_engine.sv */
module mlst_engine #(
  parameter int unsigned MAX_N       = 65535,
  parameter int unsigned PRIME_DEPTH = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mlst_pkg::cmd_e              cmd_i,
  input  logic [mlst_pkg::LimW-1:0]   index_i,
  input  logic [mlst_pkg::LimW-1:0]   lim_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output mlst_pkg::res_t              res_o
);

  localparam int unsigned Depth = MAX_N + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = (PRIME_DEPTH > 1) ? $clog2(PRIME_DEPTH) : 1;
  localparam int unsigned HW    = $clog2(PRIME_DEPTH + 1);
  localparam int unsigned EW    = PW + 3;
  localparam int unsigned LW    = mlst_pkg::LimW;

  mlst_pkg::state_e state_q, state_d;

  // entry: mark (set for composites and for primes once visited), index of smallest prime factor, mu
  logic [EW-1:0] ent_mem [Depth];
  logic [EW-1:0] ent_q;
  logic          ent_we, ent_re;
  logic [AW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata;

  logic [LW-1:0] pl_mem [PRIME_DEPTH];
  logic [LW-1:0] p_q;
  logic          pl_we, pl_re;

  logic          pf_we, pf_re;
  logic [AW-1:0] pf_waddr, pf_raddr;
  logic [LW-1:0] pf_wdata, pf_rdata;

  logic [LW-1:0]      i_q, i_d, lim_q, lim_d, idx_q, idx_d, built_q, built_d;
  logic [LW-1:0]      run_q, run_d;
  logic [HW-1:0]      held_q, held_d;
  logic [PW-1:0]      k_q, k_d, spf_q, spf_d;
  logic [1:0]         mui_q, mui_d;
  logic               brk_ok_q, brk_ok_d, brkhit_q, brkhit_d;
  logic [2*LW-1:0]    prod_q, prod_d;
  logic [mlst_pkg::PcW-1:0] pc_q, pc_d;

  logic          comp, is_prime, store, over, last_k, i_last;
  logic [1:0]    ent_mu;

  assign comp     = ent_q[EW-1];
  assign ent_mu   = ent_q[1:0];
  assign is_prime = !comp;
  assign store    = is_prime && (held_q < HW'(PRIME_DEPTH));
  assign over     = prod_q > {{LW{1'b0}}, lim_q};
  assign last_k   = over || brkhit_q || ((HW'(k_q) + HW'(1)) == held_q);
  assign i_last   = (i_q == lim_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlst_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i == mlst_pkg::CMD_QUERY) ? mlst_pkg::S_QRY : mlst_pkg::S_CLR;
        end
      end
      mlst_pkg::S_QRY: if (res_ready_i) state_d = mlst_pkg::S_IDLE;
      mlst_pkg::S_CLR: begin
        if (i_last) state_d = (lim_q == LW'(1)) ? mlst_pkg::S_SFRD : mlst_pkg::S_RDI;
      end
      mlst_pkg::S_RDI: state_d = mlst_pkg::S_EVAL;
      mlst_pkg::S_EVAL: begin
        if ((held_q + HW'(store)) != '0) state_d = mlst_pkg::S_PRD;
        else state_d = i_last ? mlst_pkg::S_SFRD : mlst_pkg::S_RDI;
      end
      mlst_pkg::S_PRD: state_d = mlst_pkg::S_MUL;
      mlst_pkg::S_MUL: state_d = mlst_pkg::S_WR;
      mlst_pkg::S_WR: begin
        if (!last_k) state_d = mlst_pkg::S_PRD;
        else state_d = i_last ? mlst_pkg::S_SFRD : mlst_pkg::S_RDI;
      end
      mlst_pkg::S_SFRD: state_d = mlst_pkg::S_SFWR;
      mlst_pkg::S_SFWR: state_d = i_last ? mlst_pkg::S_DONE : mlst_pkg::S_SFRD;
      mlst_pkg::S_DONE: if (res_ready_i) state_d = mlst_pkg::S_IDLE;
      default: state_d = mlst_pkg::S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    i_d = i_q;  lim_d = lim_q;  idx_d = idx_q;  built_d = built_q;
    run_d = run_q;  held_d = held_q;  k_d = k_q;  spf_d = spf_q;
    mui_d = mui_q;  brk_ok_d = brk_ok_q;  brkhit_d = brkhit_q;
    prod_d = prod_q;  pc_d = pc_q;
    ent_we = 1'b0;  ent_re = 1'b0;  ent_waddr = AW'(i_q);  ent_raddr = AW'(i_q);
    ent_wdata = '0;
    pl_we = 1'b0;  pl_re = 1'b0;
    pf_we = 1'b0;  pf_re = 1'b0;  pf_waddr = AW'(i_q);  pf_raddr = AW'(index_i);
    pf_wdata = '0;
    res_valid_o = 1'b0;
    res_o = '{mu: 2'sd0, sf: '0, pc: pc_q, status: mlst_pkg::ST_OK};
    case (state_q)
      mlst_pkg::S_IDLE: begin
        if (start_i) begin
          idx_d = index_i;
          if (cmd_i == mlst_pkg::CMD_QUERY) begin
            ent_re    = 1'b1;
            ent_raddr = AW'(index_i);
            pf_re     = 1'b1;
          end else begin
            lim_d  = lim_i;
            i_d    = '0;
            held_d = '0;
            pc_d   = '0;
            run_d  = '0;
          end
        end
      end
      mlst_pkg::S_QRY: begin
        res_valid_o = 1'b1;
        if (built_q == '0) begin
          res_o.status = mlst_pkg::ST_NOT_BUILT;
        end else if (idx_q > built_q) begin
          res_o.status = mlst_pkg::ST_RANGE;
        end else begin
          res_o.mu = ent_mu;
          res_o.sf = pf_rdata;
        end
      end
      mlst_pkg::S_CLR: begin
        ent_we    = 1'b1;
        ent_wdata = {1'b0, {PW{1'b0}}, (i_q == LW'(1)) ? 2'b01 : 2'b00};
        pf_we     = (i_q == '0);
        i_d       = i_last ? ((lim_q == LW'(1)) ? LW'(1) : LW'(2)) : i_q + LW'(1);
      end
      mlst_pkg::S_RDI: ent_re = 1'b1;
      mlst_pkg::S_EVAL: begin
        k_d      = '0;
        mui_d    = is_prime ? 2'b11 : ent_mu;
        spf_d    = is_prime ? PW'(held_q) : ent_q[PW+1:2];
        brk_ok_d = comp || store;
        held_d   = held_q + HW'(store);
        if (is_prime) begin
          ent_we    = 1'b1;
          ent_wdata = {1'b1, PW'(held_q), 2'b11};
          if (pc_q != mlst_pkg::PcMax) pc_d = pc_q + 1'b1;
        end
        pl_we = store;
        if ((held_q + HW'(store)) == '0) i_d = i_last ? LW'(1) : i_q + LW'(1);
      end
      mlst_pkg::S_PRD: pl_re = 1'b1;
      mlst_pkg::S_MUL: begin
        prod_d   = i_q * p_q;
        brkhit_d = brk_ok_q && (k_q == spf_q);
      end
      mlst_pkg::S_WR: begin
        if (!over) begin
          ent_we    = 1'b1;
          ent_waddr = AW'(prod_q[LW-1:0]);
          ent_wdata = {1'b1, k_q, brkhit_q ? 2'b00 : 2'(-mui_q)};
        end
        if (last_k) i_d = i_last ? LW'(1) : i_q + LW'(1);
        else k_d = k_q + 1'b1;
      end
      mlst_pkg::S_SFRD: ent_re = 1'b1;
      mlst_pkg::S_SFWR: begin
        run_d    = run_q + LW'(ent_mu != 2'b00);
        pf_we    = 1'b1;
        pf_wdata = run_d;
        if (i_last) built_d = lim_q;
        else i_d = i_q + LW'(1);
      end
      mlst_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        res_o.sf    = run_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlst_pkg::S_IDLE;
      built_q <= '0;
      pc_q    <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      pc_q    <= pc_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  lim_q <= lim_d;  idx_q <= idx_d;  run_q <= run_d;
    k_q <= k_d;  spf_q <= spf_d;  mui_q <= mui_d;
    brk_ok_q <= brk_ok_d;  brkhit_q <= brkhit_d;  prod_q <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) pl_mem[held_q[PW-1:0]] <= i_q;
    if (pl_re) p_q <= pl_mem[k_q];
  end

  mlst_pf_mem #(
    .DEPTH(Depth),
    .AW   (AW)
  ) u_pf_mem (
    .clk_i  (clk_i),
    .we_i   (pf_we),
    .waddr_i(pf_waddr),
    .wdata_i(pf_wdata),
    .re_i   (pf_re),
    .raddr_i(pf_raddr),
    .rdata_o(pf_rdata)
  );

  assign idle_o = (state_q == mlst_pkg::S_IDLE);

endmodule

/* sv/mlst_checker.sv */
module mlst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [1:0]  mobius_value_o,
  input logic [15:0]        squarefree_count_o,
  input logic [12:0]        prime_count_o,
  input logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(squarefree_count_o)
      && $stable(status_o) && $stable(mobius_value_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mlst_pkg::ST_OK |-> mobius_value_o == 2'sd0
      && squarefree_count_o == '0)
    else $error("error result carries data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3 && mobius_value_o != 2'sb10)
    else $error("bad status or mobius code");

  a_unbuilt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mlst_pkg::ST_NOT_BUILT |-> prime_count_o == '0)
    else $error("prime count before any build");

endmodule

bind mobius_linear_sieve_table mlst_checker u_mlst_checker (.*);

/* sim/tb.sv */
module tb;

  localparam int unsigned WatchLimit = 4_000_000;
  localparam int unsigned TableTop   = 65535;
  localparam int unsigned PrimeCap   = 8192;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [15:0] index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [1:0] mobius_value_o;
  logic [15:0] squarefree_count_o;
  logic [12:0] prime_count_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  mobius_linear_sieve_table dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .index_i,
    .out_valid_o,
    .out_ready_i,
    .mobius_value_o,
    .squarefree_count_o,
    .prime_count_o,
    .status_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state: its own copy of the tables and registers
  logic signed [1:0] mu_tab [0:TableTop];
  logic [15:0] sqf_tab [0:TableTop];
  bit composite [0:TableTop];
  int unsigned prime_tab [0:PrimeCap-1];
  int unsigned limit_reg = 65535;
  int unsigned built_lim = 0;
  logic [12:0] primes_seen = '0;

  mlst_pkg::res_t pending_q[$];
  int unsigned errors = 0;
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned stall_req = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // linear sieve over 1..lim, filling mu and squarefree prefix tables
  function automatic void sieve_tables(input int unsigned lim_in);
    int unsigned lim;
    int unsigned held;
    int unsigned m;
    int unsigned p;
    logic [15:0] run;
    lim = lim_in;
    if (lim == 0) lim = 1;
    if (lim > TableTop) lim = TableTop;
    for (int n = 0; n <= TableTop; n++) composite[n] = 1'b0;
    held = 0;
    primes_seen = '0;
    mu_tab[0] = 2'sd0;
    mu_tab[1] = 2'sd1;
    for (int unsigned i = 2; i <= lim; i++) begin
      if (!composite[i]) begin
        if (held < PrimeCap) begin
          prime_tab[held] = i;
          held++;
        end
        if (primes_seen != mlst_pkg::PcMax) primes_seen++;
        mu_tab[i] = -2'sd1;
      end
      for (int unsigned k = 0; k < held; k++) begin
        p = prime_tab[k];
        m = i * p;
        if (m > lim) break;
        composite[m] = 1'b1;
        if (i % p == 0) begin
          mu_tab[m] = 2'sd0;
          break;
        end
        mu_tab[m] = -mu_tab[i];
      end
    end
    run = '0;
    sqf_tab[0] = '0;
    for (int unsigned i = 1; i <= lim; i++) begin
      if (mu_tab[i] != 0) run++;
      sqf_tab[i] = run;
    end
    built_lim = lim;
  endfunction

  function automatic mlst_pkg::res_t predict_result(input mlst_pkg::cmd_e c,
                                                    input logic [15:0] idx);
    mlst_pkg::res_t r;
    r.mu = 2'sd0;
    r.sf = '0;
    r.status = mlst_pkg::ST_OK;
    if (c == mlst_pkg::CMD_BUILD) begin
      sieve_tables(limit_reg);
      r.sf = sqf_tab[built_lim];
    end else if (built_lim == 0) begin
      r.status = mlst_pkg::ST_NOT_BUILT;
    end else if (idx > built_lim) begin
      r.status = mlst_pkg::ST_RANGE;
    end else begin
      r.mu = mu_tab[idx];
      r.sf = sqf_tab[idx];
    end
    r.pc = primes_seen;
    return r;
  endfunction

  // monitor: checks result beats, then records the expectation of an input beat
  always @(posedge clk_i) begin
    mlst_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result mu=%0d sf=%0d pc=%0d st=%0d", $time,
                 mobius_value_o, squarefree_count_o, prime_count_o, status_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (mobius_value_o !== want.mu) begin
          $display("%0t: mobius_value expected %0d got %0d", $time, want.mu, mobius_value_o);
          errors++;
        end
        if (squarefree_count_o !== want.sf) begin
          $display("%0t: squarefree_count expected %0d got %0d", $time, want.sf,
                   squarefree_count_o);
          errors++;
        end
        if (prime_count_o !== want.pc) begin
          $display("%0t: prime_count expected %0d got %0d", $time, want.pc, prime_count_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      pending_q.insert(pending_q.size(),
                       predict_result(mlst_pkg::cmd_e'(cmd_i), index_i));
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // one input beat; valid stays up afterwards unless a gap or a drain lowers it
  task automatic send_item(input mlst_pkg::cmd_e c, input logic [15:0] idx);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_reg = val;
  endtask

  task automatic test_before_build();
    send_item(mlst_pkg::CMD_QUERY, 16'd0);
    send_item(mlst_pkg::CMD_QUERY, 16'hffff);
    send_item(mlst_pkg::CMD_QUERY, 16'd5);
  endtask

  // limit zero raises to one, then a few tiny limits with the edges of the range
  task automatic test_small_limits();
    write_limit(16'd0);
    send_item(mlst_pkg::CMD_BUILD, 16'hffff);
    send_item(mlst_pkg::CMD_QUERY, 16'd0);
    send_item(mlst_pkg::CMD_QUERY, 16'd1);
    send_item(mlst_pkg::CMD_QUERY, 16'd2);
    write_limit(16'd2);
    send_item(mlst_pkg::CMD_BUILD, 16'd0);
    send_item(mlst_pkg::CMD_QUERY, 16'd2);
    send_item(mlst_pkg::CMD_QUERY, 16'd3);
    write_limit(16'd30);
    send_item(mlst_pkg::CMD_BUILD, 16'd7);
    send_item(mlst_pkg::CMD_QUERY, 16'd4);
    send_item(mlst_pkg::CMD_QUERY, 16'd30);
    send_item(mlst_pkg::CMD_QUERY, 16'd31);
  endtask

  // one build over the full range, then queries at both ends of it, the middle and random indices
  task automatic test_full_range();
    write_limit(16'hffff);
    send_item(mlst_pkg::CMD_BUILD, 16'd0);
    send_item(mlst_pkg::CMD_QUERY, 16'hffff);
    send_item(mlst_pkg::CMD_QUERY, 16'hfffe);
    send_item(mlst_pkg::CMD_QUERY, 16'h8000);
    send_item(mlst_pkg::CMD_QUERY, 16'd0);
    repeat (40) send_item(mlst_pkg::CMD_QUERY, 16'($urandom));
  endtask

  // receiver holds off while queries keep coming, so the input stalls
  task automatic test_backpressure();
    stall_req = 300;
    repeat (30) send_item(mlst_pkg::CMD_QUERY, 16'($urandom_range(built_lim)));
  endtask

  function automatic logic [15:0] pick_index();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return 16'($urandom_range(built_lim));
    if (sel < 85) return 16'($urandom_range(built_lim + 3, built_lim > 3 ? built_lim - 3 : 0));
    return 16'($urandom);
  endfunction

  // random mix: mostly queries, some rebuilds at new small limits or at the same limit
  task automatic test_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) begin
        write_limit(16'($urandom_range(600, 1)));
        send_item(mlst_pkg::CMD_BUILD, 16'($urandom));
      end else if ($urandom_range(99) < 2) begin
        send_item(mlst_pkg::CMD_BUILD, 16'($urandom));
      end else begin
        send_item(mlst_pkg::CMD_QUERY, pick_index());
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_before_build();
    test_small_limits();
    test_full_range();
    test_backpressure();
    tx_idle = 32;
    rx_idle = 60;
    test_random(300);
    tx_idle = 60;
    rx_idle = 32;
    test_random(300);
    tx_idle = 0;
    rx_idle = 0;
    test_random(250);
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
